>>> hw/rtl/avg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package avg_pkg;

   localparam int FRAC_BITS_DEF  = 16;
   localparam int UNIT_SHIFT     = 30;
   localparam int DEG_BITS       = 12;
   localparam int ROOT_W         = 32;
   localparam int SQRT_PER_STAGE = 4;
   localparam int QUOT_W         = 32;
   localparam int DIV_PER_STAGE  = 4;

   localparam logic CMD_TRIANGLE = 1'b0;
   localparam logic CMD_DIAMOND  = 1'b1;

   localparam logic [1:0] IDX_TRI_LAST = 2'd2;
   localparam logic [1:0] IDX_DIA_LAST = 2'd3;

   typedef struct packed {
      logic               diamond;
      logic signed [31:0] tx;
      logic signed [31:0] ty;
      logic [30:0]        len;
      logic [30:0]        wid;
      logic               neg_x;
      logic               neg_y;
      logic               deg;
   } side_type;

   typedef struct packed {
      logic             diamond;
      logic [3:0][31:0] vx;
      logic [3:0][31:0] vy;
   } vert_type;

endpackage
`default_nettype wire

>>> hw/rtl/arrowhead_vertex_generator_top.sv
// channel | direction | ports
// request | in        | req_valid, req_stall, req_command .. req_head_width
// response| out       | rsp_valid, rsp_stall, rsp_vertex_x .. rsp_last_vertex
//
// a new word is taken as the previous one's last vertex goes out; one vertex a cycle out
// while rsp_stall is low, 3 per triangle and 4 per diamond; first vertex offered after the
// front 5, root 8, divide 9, scale 3 and output 1 register stages
// synchronous active-high reset clears valid bits and the vertex counter
// a response stall holds the pipeline once its last stage has a word; bubbles
// ahead of it still close up
`timescale 1ns / 1ps
`default_nettype none
module arrowhead_vertex_generator_top import avg_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_command,
   input  logic signed [31:0] req_tip_x,
   input  logic signed [31:0] req_tip_y,
   input  logic signed [31:0] req_tail_x,
   input  logic signed [31:0] req_tail_y,
   input  logic [30:0]        req_head_length,
   input  logic [30:0]        req_head_width,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_vertex_x,
   output logic signed [31:0] rsp_vertex_y,
   output logic [1:0]         rsp_vertex_index,
   output logic               rsp_last_vertex
);

   logic        en, load;
   logic        f_valid, s_valid, d_valid, b_valid;
   logic [62:0] f_sum;
   logic [30:0] f_nx, f_ny, s_nx, s_ny, d_qx, d_qy;
   logic [31:0] s_root;
   side_type    f_side, s_side, d_side;
   vert_type    b_vert;
   logic [31:0] vx, vy;

   assign en        = load || !b_valid;
   assign req_stall = !en;

   avg_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (req_valid),
      .command     (req_command),
      .tip_x       (req_tip_x),
      .tip_y       (req_tip_y),
      .tail_x      (req_tail_x),
      .tail_y      (req_tail_y),
      .head_length (req_head_length),
      .head_width  (req_head_width),
      .out_valid   (f_valid),
      .out_sum     (f_sum),
      .out_nx      (f_nx),
      .out_ny      (f_ny),
      .out_side    (f_side)
   );

   avg_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (f_valid),
      .in_sum    (f_sum),
      .in_nx     (f_nx),
      .in_ny     (f_ny),
      .in_side   (f_side),
      .out_valid (s_valid),
      .out_root  (s_root),
      .out_nx    (s_nx),
      .out_ny    (s_ny),
      .out_side  (s_side)
   );

   avg_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s_valid),
      .in_root   (s_root),
      .in_nx     (s_nx),
      .in_ny     (s_ny),
      .in_side   (s_side),
      .out_valid (d_valid),
      .out_qx    (d_qx),
      .out_qy    (d_qy),
      .out_side  (d_side)
   );

   avg_back u_back (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (d_valid),
      .in_qx     (d_qx),
      .in_qy     (d_qy),
      .in_side   (d_side),
      .out_valid (b_valid),
      .out_vert  (b_vert)
   );

   avg_serial u_serial (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (b_valid),
      .in_vert          (b_vert),
      .load             (load),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_vertex_x     (vx),
      .rsp_vertex_y     (vy),
      .rsp_vertex_index (rsp_vertex_index),
      .rsp_last_vertex  (rsp_last_vertex)
   );

   assign rsp_vertex_x = $signed(vx);
   assign rsp_vertex_y = $signed(vy);

endmodule
`default_nettype wire

>>> hw/rtl/avg_front.sv
`timescale 1ns / 1ps
`default_nettype none
module avg_front import avg_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic               command,
   input  logic signed [31:0] tip_x,
   input  logic signed [31:0] tip_y,
   input  logic signed [31:0] tail_x,
   input  logic signed [31:0] tail_y,
   input  logic [30:0]        head_length,
   input  logic [30:0]        head_width,
   output logic               out_valid,
   output logic [62:0]        out_sum,
   output logic [30:0]        out_nx,
   output logic [30:0]        out_ny,
   output side_type           out_side
);

   localparam logic [63:0] DEG_LIMIT = (64'd1 << (2 * FRAC_BITS)) / 64'd100000000;

   logic [4:0] vld_ff;

   // stage 0: differences and magnitudes
   logic signed [32:0] dx, dy;
   logic [32:0]        ax_w, ay_w;
   side_type           side0_in, side0_ff;
   logic [31:0]        ax0_ff, ay0_ff;

   assign dx   = {tip_x[31], tip_x} - {tail_x[31], tail_x};
   assign dy   = {tip_y[31], tip_y} - {tail_y[31], tail_y};
   assign ax_w = dx[32] ? 33'(-dx) : 33'(dx);
   assign ay_w = dy[32] ? 33'(-dy) : 33'(dy);

   always_comb begin
      side0_in.diamond = (command == CMD_DIAMOND);
      side0_in.tx      = tip_x;
      side0_in.ty      = tip_y;
      side0_in.len     = head_length;
      side0_in.wid     = head_width;
      side0_in.neg_x   = dx[32];
      side0_in.neg_y   = dy[32];
      side0_in.deg     = 1'b0;
   end

   // stage 1: degenerate test and leading-one search
   logic [31:0]               mx;
   logic [4:0]                shamt1_in, shamt1_ff;
   logic [2*DEG_BITS-1:0]     sqx_s, sqy_s;
   logic [2*DEG_BITS:0]       sq_sum;
   logic                      small_x, small_y;
   side_type                  side1_in, side1_ff;
   logic [31:0]               ax1_ff, ay1_ff;
   logic                      big1_ff;

   assign mx      = (ax0_ff > ay0_ff) ? ax0_ff : ay0_ff;
   assign small_x = (ax0_ff[31:DEG_BITS] == '0);
   assign small_y = (ay0_ff[31:DEG_BITS] == '0);
   assign sqx_s   = ax0_ff[DEG_BITS-1:0] * ax0_ff[DEG_BITS-1:0];
   assign sqy_s   = ay0_ff[DEG_BITS-1:0] * ay0_ff[DEG_BITS-1:0];
   assign sq_sum  = {1'b0, sqx_s} + {1'b0, sqy_s};

   always_comb begin
      shamt1_in = '0;
      for (int i = 0; i < 31; i++) begin
         if (mx[i]) begin
            shamt1_in = 5'(30 - i);
         end
      end
   end

   always_comb begin
      side1_in     = side0_ff;
      side1_in.deg = small_x && small_y && (64'(sq_sum) <= DEG_LIMIT);
   end

   // stage 2: normalize
   logic [30:0] nx2_in, ny2_in, nx2_ff, ny2_ff;
   side_type    side2_ff;

   assign nx2_in = big1_ff ? ax1_ff[31:1] : (ax1_ff[30:0] << shamt1_ff);
   assign ny2_in = big1_ff ? ay1_ff[31:1] : (ay1_ff[30:0] << shamt1_ff);

   // stage 3: squares
   logic [61:0] sqx3_ff, sqy3_ff;
   logic [30:0] nx3_ff, ny3_ff;
   side_type    side3_ff;

   // stage 4: sum of squares
   logic [62:0] sum4_ff;
   logic [30:0] nx4_ff, ny4_ff;
   side_type    side4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[3:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side0_ff  <= side0_in;
         ax0_ff    <= ax_w[31:0];
         ay0_ff    <= ay_w[31:0];
         side1_ff  <= side1_in;
         ax1_ff    <= ax0_ff;
         ay1_ff    <= ay0_ff;
         big1_ff   <= mx[31];
         shamt1_ff <= shamt1_in;
         side2_ff  <= side1_ff;
         nx2_ff    <= nx2_in;
         ny2_ff    <= ny2_in;
         side3_ff  <= side2_ff;
         nx3_ff    <= nx2_ff;
         ny3_ff    <= ny2_ff;
         sqx3_ff   <= {31'd0, nx2_ff} * {31'd0, nx2_ff};
         sqy3_ff   <= {31'd0, ny2_ff} * {31'd0, ny2_ff};
         side4_ff  <= side3_ff;
         nx4_ff    <= nx3_ff;
         ny4_ff    <= ny3_ff;
         sum4_ff   <= {1'b0, sqx3_ff} + {1'b0, sqy3_ff};
      end
   end

   assign out_valid = vld_ff[4];
   assign out_sum   = sum4_ff;
   assign out_nx    = nx4_ff;
   assign out_ny    = ny4_ff;
   assign out_side  = side4_ff;

endmodule
`default_nettype wire

>>> hw/rtl/avg_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
module avg_sqrt import avg_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        in_valid,
   input  logic [62:0] in_sum,
   input  logic [30:0] in_nx,
   input  logic [30:0] in_ny,
   input  side_type    in_side,
   output logic        out_valid,
   output logic [31:0] out_root,
   output logic [30:0] out_nx,
   output logic [30:0] out_ny,
   output side_type    out_side
);

   localparam int STG = ROOT_W / SQRT_PER_STAGE;

   logic [STG-1:0] vld_ff;
   logic [33:0]    rem_ff  [STG];
   logic [31:0]    root_ff [STG];
   logic [63:0]    rad_ff  [STG];
   logic [30:0]    nx_ff   [STG];
   logic [30:0]    ny_ff   [STG];
   side_type       side_ff [STG];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[STG-2:0], in_valid};
      end
   end

   for (genvar s = 0; s < STG; s++) begin : g_stg
      logic [33:0] rem_src;
      logic [31:0] root_src;
      logic [63:0] rad_src;
      logic [30:0] nx_src, ny_src;
      side_type    side_src;
      logic [33:0] rem_in;
      logic [31:0] root_in;
      logic [63:0] rad_in;

      if (s == 0) begin : g_first
         assign rem_src  = '0;
         assign root_src = '0;
         assign rad_src  = {1'b0, in_sum};
         assign nx_src   = in_nx;
         assign ny_src   = in_ny;
         assign side_src = in_side;
      end else begin : g_next
         assign rem_src  = rem_ff[s-1];
         assign root_src = root_ff[s-1];
         assign rad_src  = rad_ff[s-1];
         assign nx_src   = nx_ff[s-1];
         assign ny_src   = ny_ff[s-1];
         assign side_src = side_ff[s-1];
      end

      always_comb begin
         logic [35:0] r;
         logic [35:0] t;
         rem_in  = rem_src;
         root_in = root_src;
         rad_in  = rad_src;
         for (int j = 0; j < SQRT_PER_STAGE; j++) begin
            r      = {rem_in, rad_in[63:62]};
            t      = {2'b00, root_in, 2'b01};
            rad_in = {rad_in[61:0], 2'b00};
            if (r >= t) begin
               r       = r - t;
               root_in = {root_in[30:0], 1'b1};
            end else begin
               root_in = {root_in[30:0], 1'b0};
            end
            rem_in = r[33:0];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s]  <= rem_in;
            root_ff[s] <= root_in;
            rad_ff[s]  <= rad_in;
            nx_ff[s]   <= nx_src;
            ny_ff[s]   <= ny_src;
            side_ff[s] <= side_src;
         end
      end
   end

   assign out_valid = vld_ff[STG-1];
   assign out_root  = root_ff[STG-1];
   assign out_nx    = nx_ff[STG-1];
   assign out_ny    = ny_ff[STG-1];
   assign out_side  = side_ff[STG-1];

endmodule
`default_nettype wire

>>> hw/rtl/avg_div.sv
`timescale 1ns / 1ps
`default_nettype none
module avg_div import avg_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        in_valid,
   input  logic [31:0] in_root,
   input  logic [30:0] in_nx,
   input  logic [30:0] in_ny,
   input  side_type    in_side,
   output logic        out_valid,
   output logic [30:0] out_qx,
   output logic [30:0] out_qy,
   output side_type    out_side
);

   localparam int STG = QUOT_W / DIV_PER_STAGE;

   // setup stage: rounded numerators
   logic [61:0] numx, numy;
   logic        vld0_ff;
   logic [31:0] remx0_ff, remy0_ff, bitx0_ff, bity0_ff, den0_ff;
   side_type    side0_ff;

   assign numx = {1'b0, in_nx, 30'd0} + {31'd0, in_root[31:1]};
   assign numy = {1'b0, in_ny, 30'd0} + {31'd0, in_root[31:1]};

   logic [STG-1:0] vld_ff;
   logic [31:0]    remx_ff [STG];
   logic [31:0]    remy_ff [STG];
   logic [31:0]    bitx_ff [STG];
   logic [31:0]    bity_ff [STG];
   logic [31:0]    den_ff  [STG];
   side_type       side_ff [STG];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld0_ff <= 1'b0;
         vld_ff  <= '0;
      end else if (en) begin
         vld0_ff <= in_valid;
         vld_ff  <= {vld_ff[STG-2:0], vld0_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         remx0_ff <= {2'b00, numx[61:32]};
         remy0_ff <= {2'b00, numy[61:32]};
         bitx0_ff <= numx[31:0];
         bity0_ff <= numy[31:0];
         den0_ff  <= in_root;
         side0_ff <= in_side;
      end
   end

   for (genvar s = 0; s < STG; s++) begin : g_stg
      logic [31:0] remx_src, remy_src, bitx_src, bity_src, den_src;
      side_type    side_src;
      logic [31:0] remx_in, remy_in, bitx_in, bity_in;

      if (s == 0) begin : g_first
         assign remx_src = remx0_ff;
         assign remy_src = remy0_ff;
         assign bitx_src = bitx0_ff;
         assign bity_src = bity0_ff;
         assign den_src  = den0_ff;
         assign side_src = side0_ff;
      end else begin : g_next
         assign remx_src = remx_ff[s-1];
         assign remy_src = remy_ff[s-1];
         assign bitx_src = bitx_ff[s-1];
         assign bity_src = bity_ff[s-1];
         assign den_src  = den_ff[s-1];
         assign side_src = side_ff[s-1];
      end

      always_comb begin
         logic [32:0] rx;
         logic [32:0] ry;
         logic        qbx;
         logic        qby;
         remx_in = remx_src;
         remy_in = remy_src;
         bitx_in = bitx_src;
         bity_in = bity_src;
         for (int j = 0; j < DIV_PER_STAGE; j++) begin
            rx  = {remx_in, bitx_in[31]};
            ry  = {remy_in, bity_in[31]};
            qbx = (rx >= {1'b0, den_src});
            qby = (ry >= {1'b0, den_src});
            if (qbx) begin
               rx = rx - {1'b0, den_src};
            end
            if (qby) begin
               ry = ry - {1'b0, den_src};
            end
            remx_in = rx[31:0];
            remy_in = ry[31:0];
            bitx_in = {bitx_in[30:0], qbx};
            bity_in = {bity_in[30:0], qby};
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            remx_ff[s] <= remx_in;
            remy_ff[s] <= remy_in;
            bitx_ff[s] <= bitx_in;
            bity_ff[s] <= bity_in;
            den_ff[s]  <= den_src;
            side_ff[s] <= side_src;
         end
      end
   end

   assign out_valid = vld_ff[STG-1];
   assign out_qx    = bitx_ff[STG-1][30:0];
   assign out_qy    = bity_ff[STG-1][30:0];
   assign out_side  = side_ff[STG-1];

endmodule
`default_nettype wire

>>> hw/rtl/avg_back.sv
`timescale 1ns / 1ps
`default_nettype none
module avg_back import avg_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        in_valid,
   input  logic [30:0] in_qx,
   input  logic [30:0] in_qy,
   input  side_type    in_side,
   output logic        out_valid,
   output vert_type    out_vert
);

   localparam logic [62:0] HALF_L_TRI = 63'd1 << (UNIT_SHIFT - 1);
   localparam logic [62:0] HALF_L_DIA = 63'd1 << UNIT_SHIFT;

   function automatic logic [31:0] sat32(input logic signed [35:0] v);
      logic [31:0] r;
      if (v > 36'sd2147483647) begin
         r = 32'h7fffffff;
      end else if (v < -36'sd2147483648) begin
         r = 32'h80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   logic [2:0] vld_ff;

   // stage 0: unit magnitudes and products
   logic [30:0] ux_m, uy_m;
   logic        sx, sy;
   logic [61:0] plx_ff, ply_ff, hwx_ff, hwy_ff;
   logic        sx0_ff, sy0_ff;
   side_type    side0_ff;

   assign ux_m = in_side.deg ? 31'(1 << UNIT_SHIFT) : in_qx;
   assign uy_m = in_side.deg ? 31'd0 : in_qy;
   assign sx   = !in_side.deg && in_side.neg_x;
   assign sy   = !in_side.deg && in_side.neg_y;

   // stage 1: rounding and signs
   logic [62:0]        plx_r, ply_r, hwx_r, hwy_r;
   logic [32:0]        pxm, pym, hxm, hym;
   logic signed [33:0] px1_in, py1_in, hx1_in, hy1_in;
   logic signed [33:0] px1_ff, py1_ff, hx1_ff, hy1_ff;
   side_type           side1_ff;

   assign plx_r = {1'b0, plx_ff} + (side0_ff.diamond ? HALF_L_DIA : HALF_L_TRI);
   assign ply_r = {1'b0, ply_ff} + (side0_ff.diamond ? HALF_L_DIA : HALF_L_TRI);
   assign hwx_r = {1'b0, hwx_ff} + HALF_L_DIA;
   assign hwy_r = {1'b0, hwy_ff} + HALF_L_DIA;
   assign pxm   = side0_ff.diamond ? {1'b0, plx_r[62:UNIT_SHIFT+1]} : plx_r[62:UNIT_SHIFT];
   assign pym   = side0_ff.diamond ? {1'b0, ply_r[62:UNIT_SHIFT+1]} : ply_r[62:UNIT_SHIFT];
   assign hxm   = {1'b0, hwx_r[62:UNIT_SHIFT+1]};
   assign hym   = {1'b0, hwy_r[62:UNIT_SHIFT+1]};

   // ox = uy, oy = -ux
   assign px1_in = sx0_ff ? -$signed({1'b0, pxm}) : $signed({1'b0, pxm});
   assign py1_in = sy0_ff ? -$signed({1'b0, pym}) : $signed({1'b0, pym});
   assign hx1_in = sy0_ff ? -$signed({1'b0, hxm}) : $signed({1'b0, hxm});
   assign hy1_in = sx0_ff ? $signed({1'b0, hym}) : -$signed({1'b0, hym});

   // stage 2: vertex sums and saturation
   logic signed [35:0] tx, ty, bx, by;
   vert_type           vert2_in, vert2_ff;

   assign tx = 36'(side1_ff.tx);
   assign ty = 36'(side1_ff.ty);
   assign bx = tx - 36'(px1_ff);
   assign by = ty - 36'(py1_ff);

   always_comb begin
      vert2_in.diamond = side1_ff.diamond;
      if (side1_ff.diamond) begin
         vert2_in.vx[0] = side1_ff.tx;
         vert2_in.vy[0] = side1_ff.ty;
         vert2_in.vx[1] = sat32(bx - 36'(hx1_ff));
         vert2_in.vy[1] = sat32(by - 36'(hy1_ff));
         vert2_in.vx[2] = sat32(bx - 36'(px1_ff));
         vert2_in.vy[2] = sat32(by - 36'(py1_ff));
         vert2_in.vx[3] = sat32(bx + 36'(hx1_ff));
         vert2_in.vy[3] = sat32(by + 36'(hy1_ff));
      end else begin
         vert2_in.vx[0] = sat32(bx - 36'(hx1_ff));
         vert2_in.vy[0] = sat32(by - 36'(hy1_ff));
         vert2_in.vx[1] = side1_ff.tx;
         vert2_in.vy[1] = side1_ff.ty;
         vert2_in.vx[2] = sat32(bx + 36'(hx1_ff));
         vert2_in.vy[2] = sat32(by + 36'(hy1_ff));
         vert2_in.vx[3] = side1_ff.tx;
         vert2_in.vy[3] = side1_ff.ty;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         plx_ff   <= {31'd0, ux_m} * {31'd0, in_side.len};
         ply_ff   <= {31'd0, uy_m} * {31'd0, in_side.len};
         hwx_ff   <= {31'd0, uy_m} * {31'd0, in_side.wid};
         hwy_ff   <= {31'd0, ux_m} * {31'd0, in_side.wid};
         sx0_ff   <= sx;
         sy0_ff   <= sy;
         side0_ff <= in_side;
         px1_ff   <= px1_in;
         py1_ff   <= py1_in;
         hx1_ff   <= hx1_in;
         hy1_ff   <= hy1_in;
         side1_ff <= side0_ff;
         vert2_ff <= vert2_in;
      end
   end

   assign out_valid = vld_ff[2];
   assign out_vert  = vert2_ff;

endmodule
`default_nettype wire

>>> hw/rtl/avg_serial.sv
`timescale 1ns / 1ps
`default_nettype none
module avg_serial import avg_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  vert_type    in_vert,
   output logic        load,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_vertex_x,
   output logic [31:0] rsp_vertex_y,
   output logic [1:0]  rsp_vertex_index,
   output logic        rsp_last_vertex
);

   logic       hold_ff;
   logic [1:0] idx_ff;
   vert_type   vert_ff;
   logic       last;
   logic       fire;

   assign last = vert_ff.diamond ? (idx_ff == IDX_DIA_LAST) : (idx_ff == IDX_TRI_LAST);
   assign fire = hold_ff && !rsp_stall;
   assign load = !hold_ff || (fire && last);

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= 1'b0;
         idx_ff  <= '0;
      end else if (load) begin
         hold_ff <= in_valid;
         idx_ff  <= '0;
      end else if (fire) begin
         idx_ff  <= idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         vert_ff <= in_vert;
      end
   end

   assign rsp_valid        = hold_ff;
   assign rsp_vertex_x     = vert_ff.vx[idx_ff];
   assign rsp_vertex_y     = vert_ff.vy[idx_ff];
   assign rsp_vertex_index = idx_ff;
   assign rsp_last_vertex  = last;

endmodule
`default_nettype wire
